FILE: src/smt_pkg.sv
package smt_pkg;

   // Default sizing
   localparam int CAPACITY_DEF    = 1024;
   localparam int VALUE_WIDTH_DEF = 32;

   // Port field widths
   localparam int KIND_W   = 3;
   localparam int HANDLE_W = 10;
   localparam int POS_W    = 10;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 3'd0,
      KIND_ERASE_H = 3'd1,
      KIND_ERASE_P = 3'd2,
      KIND_QUERY   = 3'd3,
      KIND_READ_H  = 3'd4,
      KIND_READ_P  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DEAD  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

endpackage

FILE: src/slot_map_table.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   kind, handle, position, value_a..value_d
// rsp_      out        rsp_valid / rsp_stall   status, result_handle, present, out_a..out_d, row_count
//
// One item at a time, sequenced around two registered-read memories (handle map; rows + owner).
// Each item runs S_LOOK, S_CHECK, S_RESP; a handle lookup that passes adds S_VERIFY, an erase adds
// S_FREE, and moving the last row into the hole adds S_MOVE; a rejected beat or a missed lookup
// leaves early for S_RESP.
// Synchronous reset clears counts, free list head, sequencer and response valid; the memories are not cleared.
// A stalled response beat is held; the next request's response waits in S_RESP.
module slot_map_table
   import smt_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [HANDLE_W-1:0]      req_handle,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value_a,
   input  logic signed [DATA_W-1:0] req_value_b,
   input  logic signed [DATA_W-1:0] req_value_c,
   input  logic signed [DATA_W-1:0] req_value_d,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [HANDLE_W-1:0]      rsp_result_handle,
   output logic                     rsp_present,
   output logic signed [DATA_W-1:0] rsp_out_a,
   output logic signed [DATA_W-1:0] rsp_out_b,
   output logic signed [DATA_W-1:0] rsp_out_c,
   output logic signed [DATA_W-1:0] rsp_out_d,
   output logic [COUNT_W-1:0]       rsp_row_count
);

   localparam int AW = $clog2(CAPACITY);        // handle / position index
   localparam int CW = $clog2(CAPACITY + 1);    // counts and free list links
   localparam int VW = VALUE_WIDTH;
   localparam int RW = AW + 4 * VW;             // row: owner, d, c, b, a

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_CHECK,
      S_VERIFY,
      S_MOVE,
      S_FREE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [POS_W-1:0]    position_ff, position_in;
   logic [VW-1:0]       val_a_ff, val_a_in;
   logic [VW-1:0]       val_b_ff, val_b_in;
   logic [VW-1:0]       val_c_ff, val_c_in;
   logic [VW-1:0]       val_d_ff, val_d_in;

   // table state
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic [CW-1:0] free_head_ff, free_head_in;

   // erase working registers
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] id_ff, id_in;

   // staged result
   status_type          res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                res_present_ff, res_present_in;
   logic                res_row_ff, res_row_in;

   // response beat
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic                     rsp_present_ff, rsp_present_in;
   logic signed [DATA_W-1:0] rsp_a_ff, rsp_a_in;
   logic signed [DATA_W-1:0] rsp_b_ff, rsp_b_in;
   logic signed [DATA_W-1:0] rsp_c_ff, rsp_c_in;
   logic signed [DATA_W-1:0] rsp_d_ff, rsp_d_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // memory ports
   logic          hm_we, hm_re;
   logic [AW-1:0] hm_waddr, hm_raddr;
   logic [CW-1:0] hm_wdata, hm_rdata;
   logic          row_we, row_re;
   logic [AW-1:0] row_waddr, row_raddr;
   logic [RW-1:0] row_wdata, row_rdata;

   logic                 req_accept;
   logic [AW-1:0]        row_owner;
   logic signed [VW-1:0] col_a, col_b, col_c, col_d;
   logic [AW-1:0]        last_pos;
   logic [AW-1:0]        erase_pos;
   logic                 fresh_handle;
   logic                 insert_full;
   logic [AW-1:0]        new_handle;
   logic                 handle_ok;
   logic                 position_ok;

   smt_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_handle_map (
      .clock   (clock),
      .wr_en   (hm_we),
      .wr_addr (hm_waddr),
      .wr_data (hm_wdata),
      .rd_en   (hm_re),
      .rd_addr (hm_raddr),
      .rd_data (hm_rdata)
   );

   smt_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_row_store (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign row_owner = row_rdata[RW-1 -: AW];
   assign col_a     = row_rdata[0*VW +: VW];
   assign col_b     = row_rdata[1*VW +: VW];
   assign col_c     = row_rdata[2*VW +: VW];
   assign col_d     = row_rdata[3*VW +: VW];

   assign last_pos  = AW'(live_ff - 1'b1);
   assign erase_pos = (state_ff == S_CHECK) ? AW'(position_ff) : pos_ff;

   // free list empty when the head has caught up with the issue count
   assign fresh_handle = (free_head_ff == issued_ff);
   assign insert_full  = (32'(live_ff) >= CAPACITY)
                      || (fresh_handle && (32'(issued_ff) >= CAPACITY))
                      || (!fresh_handle && (32'(free_head_ff) >= CAPACITY));
   assign new_handle   = fresh_handle ? AW'(issued_ff) : AW'(free_head_ff);

   // first-level liveness: handle issued and its map entry inside the rows
   assign handle_ok   = (32'(handle_ff) < 32'(issued_ff))
                     && (32'(handle_ff) < CAPACITY)
                     && (hm_rdata < live_ff);
   assign position_ok = (32'(position_ff) < 32'(live_ff))
                     && (32'(position_ff) < CAPACITY);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      handle_in      = handle_ff;
      position_in    = position_ff;
      val_a_in       = val_a_ff;
      val_b_in       = val_b_ff;
      val_c_in       = val_c_ff;
      val_d_in       = val_d_ff;
      live_in        = live_ff;
      issued_in      = issued_ff;
      free_head_in   = free_head_ff;
      pos_in         = pos_ff;
      id_in          = id_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_present_in = res_present_ff;
      res_row_in     = res_row_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_present_in = rsp_present_ff;
      rsp_a_in       = rsp_a_ff;
      rsp_b_in       = rsp_b_ff;
      rsp_c_in       = rsp_c_ff;
      rsp_d_in       = rsp_d_ff;
      rsp_count_in   = rsp_count_ff;

      hm_we     = 1'b0;
      hm_waddr  = '0;
      hm_wdata  = '0;
      hm_re     = 1'b0;
      hm_raddr  = '0;
      row_we    = 1'b0;
      row_waddr = '0;
      row_wdata = '0;
      row_re    = 1'b0;
      row_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in        = req_kind;
               handle_in      = req_handle;
               position_in    = req_position;
               val_a_in       = VW'($unsigned(req_value_a));
               val_b_in       = VW'($unsigned(req_value_b));
               val_c_in       = VW'($unsigned(req_value_c));
               val_d_in       = VW'($unsigned(req_value_d));
               res_status_in  = STATUS_OK;
               res_handle_in  = '0;
               res_present_in = 1'b0;
               res_row_in     = 1'b0;
               state_in       = S_LOOK;
            end
         end

         S_LOOK: begin
            // insert looks up the free list link, the rest the handle's slot
            hm_re     = 1'b1;
            hm_raddr  = (kind_ff == KIND_INSERT) ? AW'(free_head_ff) : AW'(handle_ff);
            row_re    = 1'b1;
            row_raddr = AW'(position_ff);
            state_in  = S_CHECK;
         end

         S_CHECK: begin
            state_in = S_RESP;
            case (kind_ff)
               KIND_INSERT: begin
                  if (insert_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     if (fresh_handle) begin
                        issued_in    = issued_ff + 1'b1;
                        free_head_in = issued_ff + 1'b1;
                     end else begin
                        free_head_in = hm_rdata;
                     end
                     hm_we         = 1'b1;
                     hm_waddr      = new_handle;
                     hm_wdata      = live_ff;
                     row_we        = 1'b1;
                     row_waddr     = AW'(live_ff);
                     row_wdata     = {new_handle, val_d_ff, val_c_ff, val_b_ff, val_a_ff};
                     live_in       = live_ff + 1'b1;
                     res_handle_in = HANDLE_W'(new_handle);
                  end
               end
               KIND_ERASE_H, KIND_QUERY, KIND_READ_H: begin
                  if (handle_ok) begin
                     // confirm through the reverse map
                     pos_in    = AW'(hm_rdata);
                     row_re    = 1'b1;
                     row_raddr = AW'(hm_rdata);
                     state_in  = S_VERIFY;
                  end else if (kind_ff != KIND_QUERY) begin
                     res_status_in = STATUS_DEAD;
                  end
               end
               KIND_ERASE_P: begin
                  if (position_ok) begin
                     pos_in = AW'(position_ff);
                     id_in  = row_owner;
                     if (erase_pos != last_pos) begin
                        row_re    = 1'b1;
                        row_raddr = last_pos;
                        state_in  = S_MOVE;
                     end else begin
                        state_in  = S_FREE;
                     end
                  end else begin
                     res_status_in = STATUS_RANGE;
                  end
               end
               KIND_READ_P: begin
                  if (position_ok) begin
                     res_row_in    = 1'b1;
                     res_handle_in = HANDLE_W'(row_owner);
                  end else begin
                     res_status_in = STATUS_RANGE;
                  end
               end
               default: begin
                  // unused kinds: no change, count only
               end
            endcase
         end

         S_VERIFY: begin
            state_in = S_RESP;
            if (32'(row_owner) != 32'(handle_ff)) begin
               if (kind_ff != KIND_QUERY) begin
                  res_status_in = STATUS_DEAD;
               end
            end else begin
               case (kind_ff)
                  KIND_QUERY: begin
                     res_present_in = 1'b1;
                  end
                  KIND_READ_H: begin
                     res_row_in    = 1'b1;
                     res_handle_in = handle_ff;
                  end
                  KIND_ERASE_H: begin
                     id_in = row_owner;
                     if (erase_pos != last_pos) begin
                        row_re    = 1'b1;
                        row_raddr = last_pos;
                        state_in  = S_MOVE;
                     end else begin
                        state_in  = S_FREE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_MOVE: begin
            // last row into the hole, and repoint its owner
            row_we    = 1'b1;
            row_waddr = pos_ff;
            row_wdata = row_rdata;
            hm_we     = 1'b1;
            hm_waddr  = row_owner;
            hm_wdata  = CW'(pos_ff);
            state_in  = S_FREE;
         end

         S_FREE: begin
            // push the erased handle onto the free list
            hm_we        = 1'b1;
            hm_waddr     = id_ff;
            hm_wdata     = free_head_ff;
            free_head_in = CW'(id_ff);
            live_in      = live_ff - 1'b1;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_handle_in  = res_handle_ff;
               rsp_present_in = res_present_ff;
               rsp_a_in       = res_row_ff ? DATA_W'(col_a) : '0;
               rsp_b_in       = res_row_ff ? DATA_W'(col_b) : '0;
               rsp_c_in       = res_row_ff ? DATA_W'(col_c) : '0;
               rsp_d_in       = res_row_ff ? DATA_W'(col_d) : '0;
               rsp_count_in   = COUNT_W'(live_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         issued_ff    <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         issued_ff    <= issued_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      handle_ff      <= handle_in;
      position_ff    <= position_in;
      val_a_ff       <= val_a_in;
      val_b_ff       <= val_b_in;
      val_c_ff       <= val_c_in;
      val_d_ff       <= val_d_in;
      pos_ff         <= pos_in;
      id_ff          <= id_in;
      res_status_ff  <= res_status_in;
      res_handle_ff  <= res_handle_in;
      res_present_ff <= res_present_in;
      res_row_ff     <= res_row_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_present_ff <= rsp_present_in;
      rsp_a_ff       <= rsp_a_in;
      rsp_b_ff       <= rsp_b_in;
      rsp_c_ff       <= rsp_c_in;
      rsp_d_ff       <= rsp_d_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_present       = rsp_present_ff;
   assign rsp_out_a         = rsp_a_ff;
   assign rsp_out_b         = rsp_b_ff;
   assign rsp_out_c         = rsp_c_ff;
   assign rsp_out_d         = rsp_d_ff;
   assign rsp_row_count     = rsp_count_ff;

endmodule

FILE: src/smt_ram.sv
module smt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import smt_pkg::*;

   localparam int CAP = CAPACITY_DEF;

   // Kinds the block decodes as no-ops
   localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ONES = -32'sd1;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [HANDLE_W-1:0]      handle;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
   } req_beat_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [HANDLE_W-1:0]      handle;
      logic                     present;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
      logic [COUNT_W-1:0]       row_count;
   } rsp_beat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
   } row_type;

   // DUT ports; every input is known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind = '0;
   logic [HANDLE_W-1:0]      req_handle = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value_a = '0;
   logic signed [DATA_W-1:0] req_value_b = '0;
   logic signed [DATA_W-1:0] req_value_c = '0;
   logic signed [DATA_W-1:0] req_value_d = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [HANDLE_W-1:0]      rsp_result_handle;
   logic                     rsp_present;
   logic signed [DATA_W-1:0] rsp_out_a;
   logic signed [DATA_W-1:0] rsp_out_b;
   logic signed [DATA_W-1:0] rsp_out_c;
   logic signed [DATA_W-1:0] rsp_out_d;
   logic [COUNT_W-1:0]       rsp_row_count;

   slot_map_table dut (.*);

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the table: forward map, reverse map, dense rows and counters
   logic [COUNT_W-1:0]  fwd_map   [CAP];
   logic [HANDLE_W-1:0] row_owner [CAP];
   row_type             row_store [CAP];
   int                  live_rows = 0;
   int                  issued    = 0;
   int                  free_head = 0;

   // Results still owed by the block, oldest first
   rsp_beat_type awaited[$];
   int           fail_count = 0;

   // Idling knobs, in percent per cycle
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Long receiver hold-off, asked for by the stimulus, counted by the receiver
   bit hold_ask  = 1'b0;
   int hold_left = 0;

   // Directed script; fixed rows carry a hand-written expected beat
   req_beat_type script_req[$];
   rsp_beat_type script_rsp[$];
   bit           script_fixed[$];

   function automatic bit handle_live(logic [HANDLE_W-1:0] h);
      int pos;
      if (int'(h) >= issued)
         return 1'b0;
      pos = int'(fwd_map[h]);
      if (pos >= live_rows)
         return 1'b0;
      return row_owner[pos] == h;
   endfunction

   // Fill the hole with the last row, then push the freed handle
   task automatic drop_row(int pos);
      int id;
      int last;
      id   = int'(row_owner[pos]);
      last = live_rows - 1;
      if (pos != last) begin
         row_store[pos] = row_store[last];
         row_owner[pos] = row_owner[last];
         fwd_map[row_owner[pos]] = COUNT_W'(pos);
      end
      live_rows   = last;
      fwd_map[id] = COUNT_W'(free_head);
      free_head   = id;
   endtask

   task automatic slot_map_predict(input req_beat_type q, output rsp_beat_type r);
      int nh;
      int pos;
      r  = '0;
      nh = -1;
      case (q.kind)
         KIND_INSERT: begin
            if (live_rows >= CAP)
               r.status = STATUS_FULL;
            else if (free_head == issued) begin
               if (issued >= CAP)
                  r.status = STATUS_FULL;
               else begin
                  nh        = issued;
                  issued    = issued + 1;
                  free_head = issued;
               end
            end else if (free_head >= CAP)
               r.status = STATUS_FULL;
            else begin
               nh        = free_head;
               free_head = int'(fwd_map[nh]);
            end
            if (nh >= 0) begin
               fwd_map[nh]          = COUNT_W'(live_rows);
               row_owner[live_rows] = HANDLE_W'(nh);
               row_store[live_rows] = {q.a, q.b, q.c, q.d};
               live_rows            = live_rows + 1;
               r.handle             = HANDLE_W'(nh);
            end
         end
         KIND_ERASE_H: begin
            if (!handle_live(q.handle))
               r.status = STATUS_DEAD;
            else
               drop_row(int'(fwd_map[q.handle]));
         end
         KIND_ERASE_P: begin
            if (int'(q.position) >= live_rows)
               r.status = STATUS_RANGE;
            else
               drop_row(int'(q.position));
         end
         KIND_QUERY: r.present = handle_live(q.handle);
         KIND_READ_H: begin
            if (!handle_live(q.handle))
               r.status = STATUS_DEAD;
            else begin
               pos                  = int'(fwd_map[q.handle]);
               {r.a, r.b, r.c, r.d} = row_store[pos];
               r.handle             = q.handle;
            end
         end
         KIND_READ_P: begin
            if (int'(q.position) >= live_rows)
               r.status = STATUS_RANGE;
            else begin
               {r.a, r.b, r.c, r.d} = row_store[q.position];
               r.handle             = row_owner[q.position];
            end
         end
         default: ;
      endcase
      r.row_count = COUNT_W'(live_rows);
   endtask

   task automatic put(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] h,
                      logic [POS_W-1:0] p, logic signed [DATA_W-1:0] a,
                      logic signed [DATA_W-1:0] b, logic signed [DATA_W-1:0] c,
                      logic signed [DATA_W-1:0] d);
      script_req.insert(script_req.size(), {kind, h, p, a, b, c, d});
      script_rsp.insert(script_rsp.size(), '0);
      script_fixed.insert(script_fixed.size(), 1'b0);
   endtask

   // Pin the expected beat of the row just added
   task automatic want(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] h, logic pr,
                       logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
                       logic signed [DATA_W-1:0] c, logic signed [DATA_W-1:0] d,
                       logic [COUNT_W-1:0] n);
      script_rsp[script_rsp.size() - 1]     = {st, h, pr, a, b, c, d, n};
      script_fixed[script_fixed.size() - 1] = 1'b1;
   endtask

   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 15))
         0:       return VMAX;
         1:       return VMIN;
         2:       return ONES;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Random beat; most handle and position ops aim at a live row
   function automatic req_beat_type make_beat(int ins_pct);
      req_beat_type q;
      int           roll;
      q.handle   = HANDLE_W'($urandom);
      q.position = POS_W'($urandom);
      q.a        = rand_value();
      q.b        = rand_value();
      q.c        = rand_value();
      q.d        = rand_value();
      roll       = $urandom_range(0, 99);
      if (roll < ins_pct)
         q.kind = KIND_INSERT;
      else if (roll >= 97)
         q.kind = roll[0] ? KIND_SPARE7 : KIND_SPARE6;
      else begin
         case ($urandom_range(0, 4))
            0:       q.kind = KIND_ERASE_H;
            1:       q.kind = KIND_ERASE_P;
            2:       q.kind = KIND_QUERY;
            3:       q.kind = KIND_READ_H;
            default: q.kind = KIND_READ_P;
         endcase
         if (live_rows > 0 && $urandom_range(0, 9) < 8) begin
            q.position = POS_W'($urandom_range(0, live_rows - 1));
            q.handle   = row_owner[q.position];
         end
      end
      return q;
   endfunction

   // One request beat: optional idle cycles, offer, hold until taken, predict
   task automatic send_beat(input req_beat_type q, input bit fixed, input rsp_beat_type w);
      rsp_beat_type guess;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= q.kind;
      req_handle   <= q.handle;
      req_position <= q.position;
      req_value_a  <= q.a;
      req_value_b  <= q.b;
      req_value_c  <= q.c;
      req_value_d  <= q.d;
      do
         @(posedge clock);
      while (req_stall);
      slot_map_predict(q, guess);
      awaited.insert(awaited.size(), fixed ? w : guess);
   endtask

   // Sender pauses until every owed beat is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited.size() != 0)
         @(posedge clock);
   endtask

   task automatic flag_failure(string why, rsp_beat_type w, rsp_beat_type s);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: expected st=%0d h=%0d pr=%0b %h %h %h %h n=%0d",
                  why, w.status, w.handle, w.present, w.a, w.b, w.c, w.d, w.row_count,
                  " / got st=%0d h=%0d pr=%0b %h %h %h %h n=%0d",
                  s.status, s.handle, s.present, s.a, s.b, s.c, s.d, s.row_count);
   endtask

   // Receiver: random stall per cycle, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_left = 400;
         hold_ask  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Every result beat taken is matched against the oldest owed beat
   always @(posedge clock) begin : result_check
      rsp_beat_type seen;
      rsp_beat_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_status, rsp_result_handle, rsp_present, rsp_out_a, rsp_out_b,
                 rsp_out_c, rsp_out_d, rsp_row_count};
         if (awaited.size() == 0)
            flag_failure("unexpected beat", '0, seen);
         else begin
            owed = awaited.pop_front();
            if (seen.status !== owed.status || seen.handle !== owed.handle ||
                seen.present !== owed.present || seen.a !== owed.a ||
                seen.b !== owed.b || seen.c !== owed.c || seen.d !== owed.d ||
                seen.row_count !== owed.row_count)
               flag_failure("mismatch", owed, seen);
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: every lookup misses, no-op kinds answer zeros
      put(KIND_QUERY, 0, 0, 0, 0, 0, 0);         want(STATUS_OK, 0, 0, 0, 0, 0, 0, 0);
      put(KIND_READ_H, 1023, 0, 0, 0, 0, 0);     want(STATUS_DEAD, 0, 0, 0, 0, 0, 0, 0);
      put(KIND_ERASE_H, 0, 0, 0, 0, 0, 0);       want(STATUS_DEAD, 0, 0, 0, 0, 0, 0, 0);
      put(KIND_ERASE_P, 0, 0, 0, 0, 0, 0);       want(STATUS_RANGE, 0, 0, 0, 0, 0, 0, 0);
      put(KIND_READ_P, 0, 1023, 0, 0, 0, 0);     want(STATUS_RANGE, 0, 0, 0, 0, 0, 0, 0);
      put(KIND_SPARE6, 1023, 1023, ONES, ONES, ONES, ONES);
      want(STATUS_OK, 0, 0, 0, 0, 0, 0, 0);
      // Two rows of extreme values, read back both ways
      put(KIND_INSERT, 0, 0, VMAX, VMIN, 0, ONES);
      want(STATUS_OK, 0, 0, 0, 0, 0, 0, 1);
      put(KIND_INSERT, 1023, 1023, ONES, 0, VMIN, VMAX);
      want(STATUS_OK, 1, 0, 0, 0, 0, 0, 2);
      put(KIND_READ_P, 0, 0, 0, 0, 0, 0);        want(STATUS_OK, 0, 0, VMAX, VMIN, 0, ONES, 2);
      put(KIND_READ_H, 1, 0, 0, 0, 0, 0);        want(STATUS_OK, 1, 0, ONES, 0, VMIN, VMAX, 2);
      put(KIND_QUERY, 1, 0, 0, 0, 0, 0);         want(STATUS_OK, 0, 1, 0, 0, 0, 0, 2);
      put(KIND_QUERY, 1023, 0, 0, 0, 0, 0);      want(STATUS_OK, 0, 0, 0, 0, 0, 0, 2);
      put(KIND_INSERT, 0, 0, $urandom, $urandom, $urandom, $urandom);
      // Erase the first row: last row moves into the hole
      put(KIND_ERASE_H, 0, 0, 0, 0, 0, 0);       want(STATUS_OK, 0, 0, 0, 0, 0, 0, 2);
      put(KIND_READ_P, 0, 0, 0, 0, 0, 0);
      // Erase of the last row: counts and free list only
      put(KIND_ERASE_P, 0, 1, 0, 0, 0, 0);
      put(KIND_ERASE_H, 0, 0, 0, 0, 0, 0);       want(STATUS_DEAD, 0, 0, 0, 0, 0, 0, 1);
      // Free list pops handles back, then a fresh handle is issued
      put(KIND_INSERT, 0, 0, $urandom, $urandom, $urandom, $urandom);
      put(KIND_INSERT, 0, 0, $urandom, $urandom, $urandom, $urandom);
      put(KIND_INSERT, 0, 0, $urandom, $urandom, $urandom, $urandom);
      put(KIND_READ_P, 0, 4, 0, 0, 0, 0);        want(STATUS_RANGE, 0, 0, 0, 0, 0, 0, 4);
      put(KIND_SPARE7, 0, 0, 0, 0, 0, 0);        want(STATUS_OK, 0, 0, 0, 0, 0, 0, 4);
      put(KIND_READ_H, 2, 0, 0, 0, 0, 0);
      put(KIND_ERASE_P, 0, 0, 0, 0, 0, 0);

      foreach (script_req[i])
         send_beat(script_req[i], script_fixed[i], script_rsp[i]);
      settle();

      // Mixed traffic under each idling pattern; the first one also sees a long
      // receiver hold-off so that the block backs up and stalls its input
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_ask = 1'b1; end
            1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         repeat (150)
            send_beat(make_beat(40), 1'b0, '0);
         settle();
      end

      // Fill the table to capacity, then knock on the full table
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      while (live_rows < CAP)
         send_beat(make_beat(92), 1'b0, '0);
      repeat (4)
         send_beat(make_beat(100), 1'b0, '0);
      repeat (10)
         send_beat(make_beat(60), 1'b0, '0);
      settle();

      // Drain, with few inserts among the erases and lookups
      send_idle_pct  = 67;
      recv_stall_pct = 0;
      repeat (250)
         send_beat(make_beat(10), 1'b0, '0);
      settle();

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #6_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
